>>> rtl/jitter_tracking_frame_queue_drop_macros.svh
// Assertion macros for the frame queue RTL.
// Included by jtq_ctrl, the module that carries concurrent checks.
`ifndef JITTER_TRACKING_FRAME_QUEUE_DROP_MACROS_SVH
`define JITTER_TRACKING_FRAME_QUEUE_DROP_MACROS_SVH
// Check an implication on the rising clock, disabled in reset.
`define JTQ_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check a property that also holds during reset.
`define JTQ_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

>>> rtl/jtq_pkg.sv
// Package for the jitter tracking frame queue: constants, command and status types.
// No dependencies.
`timescale 1ns / 1ps
package jtq_pkg;
    localparam int DEF_QUEUE_DEPTH = 64;
    localparam int DEF_TIME_BITS   = 40;
    localparam int MUL_W    = 16;
    localparam int ALPHA_W  = 16;
    localparam int MARGIN_W = 18;
    localparam int PERIOD_W = 20;
    localparam int CAP_W    = 20;
    localparam int PEAK_W   = 20;
    localparam int OUT_TW   = 40;
    localparam int CNT_OUT_W = 7;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 20;
    // divide operand: term saturated at 2^62 plus margin/peak headroom
    localparam int DIV_W = 64;

    localparam logic [CFG_IDX_W-1:0] REG_MUL    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MARGIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CAP    = 3'd4;

    typedef struct packed {
        logic load;      // capture event
        logic track;     // run the jitter tracker multiplies
        logic track_fin; // commit tracker result
        logic mem_rd;    // take the head entry from the read data
        logic mem_wr;    // write new frame
        logic pop;       // advance head
        logic term;      // compute division operand
        logic div_start;
        logic drop_one;
        logic out_load;
    } jtq_cmd_t;

    typedef struct packed {
        logic is_dep;
        logic full;
        logic empty;
        logic div_done;
        logic over_safe;
    } jtq_stat_t;
endpackage

>>> rtl/jtq_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module jtq_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> rtl/jtq_div.sv
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on jtq_pkg.
`timescale 1ns / 1ps
module jtq_div
    import jtq_pkg::*;
#(
    parameter int N = DIV_W,
    parameter int D = PERIOD_W
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [N-1:0] dividend,
    input  logic [D-1:0] divisor,
    output logic         done,
    output logic [N-1:0] quotient
);
    localparam int CW = $clog2(N + 1);
    logic [N-1:0] q_reg, q_next;
    logic [D:0]   r_reg, r_next;
    logic [D-1:0] dv_reg, dv_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic busy_reg, busy_next, done_reg, done_next;
    logic [D+1:0] trial;

    always_comb
    begin
        q_next = q_reg;
        r_next = r_reg;
        dv_next = dv_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial = '0;
        if (start)
        begin
            q_next = dividend;
            r_next = '0;
            dv_next = divisor;
            cnt_next = CW'(N);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            trial = {r_reg, q_reg[N-1]} - {2'b00, dv_reg};
            if (!trial[D+1])
            begin
                r_next = trial[D:0];
                q_next = {q_reg[N-2:0], 1'b1};
            end
            else
            begin
                r_next = {r_reg[D-1:0], q_reg[N-1]};
                q_next = {q_reg[N-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        dv_reg <= dv_next;
    end

    assign done = done_reg;
    assign quotient = q_reg;
endmodule

>>> rtl/jtq_datapath.sv
// Datapath of the frame queue: config registers, trackers, FIFO pointers,
// safe-length term and divider. Depends on jtq_pkg, jtq_ram, jtq_div.
`timescale 1ns / 1ps
module jtq_datapath
    import jtq_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int TIME_BITS   = DEF_TIME_BITS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_idx,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_action,
    input  logic [OUT_TW-1:0]     in_time,
    input  jtq_cmd_t              cmd,
    output jtq_stat_t             stat,
    output logic [OUT_TW+OUT_TW+3*CNT_OUT_W+1:0] result
);
    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [63:0] SAT = 64'd1 << 62;

    logic [MUL_W-1:0] mul_reg;
    logic [ALPHA_W-1:0] alpha_reg;
    logic signed [MARGIN_W-1:0] margin_reg;
    logic [PERIOD_W-1:0] period_reg;
    logic [CAP_W-1:0] cap_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_reg <= MUL_W'(512);
            alpha_reg <= ALPHA_W'(65208);
            margin_reg <= '0;
            period_reg <= PERIOD_W'(20000);
            cap_reg <= CAP_W'(100000);
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                REG_MUL:    mul_reg <= cfg_data[MUL_W-1:0];
                REG_ALPHA:  alpha_reg <= cfg_data[ALPHA_W-1:0];
                REG_MARGIN: margin_reg <= cfg_data[MARGIN_W-1:0];
                REG_PERIOD: period_reg <= cfg_data[PERIOD_W-1:0];
                REG_CAP:    cap_reg <= cfg_data[CAP_W-1:0];
                default: ;
            endcase
        end
    end

    logic act_reg;
    logic [TIME_BITS-1:0] now_reg;
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg <= in_action;
            now_reg <= TIME_BITS'(in_time);
        end
    end

    // tracker state, selected by event kind
    logic [TIME_BITS-1:0] in_exp_reg, out_exp_reg;
    logic [PEAK_W-1:0] in_peak_reg, out_peak_reg;
    logic in_pr_reg, out_pr_reg;
    logic [TIME_BITS-1:0] exp_sel, jit_dist;
    logic [PEAK_W-1:0] peak_sel;
    logic pr_sel;
    logic [32:0] dclamp;
    logic [48:0] fresh_reg;
    logic [35:0] held_reg;
    logic [40:0] fresh_sh;
    logic [19:0] held_sh;
    logic [PEAK_W-1:0] peak_new;

    assign exp_sel  = act_reg ? out_exp_reg : in_exp_reg;
    assign peak_sel = act_reg ? out_peak_reg : in_peak_reg;
    assign pr_sel   = act_reg ? out_pr_reg : in_pr_reg;
    assign jit_dist = (exp_sel >= now_reg) ? exp_sel - now_reg : now_reg - exp_sel;

    always_comb
    begin
        if (TIME_BITS > 32 && (jit_dist >> 32) != '0)
        begin
            dclamp = 33'h1_0000_0000;
        end
        else
        begin
            dclamp = 33'(jit_dist);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.track)
        begin
            fresh_reg <= dclamp * mul_reg;
            held_reg <= peak_sel * alpha_reg;
        end
    end

    assign fresh_sh = fresh_reg[48:8];
    assign held_sh = held_reg[35:16];
    always_comb
    begin
        if (fresh_sh > 41'(held_sh))
        begin
            peak_new = (fresh_sh > 41'(cap_reg)) ? cap_reg : fresh_sh[PEAK_W-1:0];
        end
        else
        begin
            peak_new = (held_sh > cap_reg) ? cap_reg : held_sh;
        end
    end

    logic [TIME_BITS-1:0] exp_new;
    assign exp_new = now_reg + TIME_BITS'(period_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_exp_reg <= '0;
            out_exp_reg <= '0;
            in_peak_reg <= '0;
            out_peak_reg <= '0;
            in_pr_reg <= 1'b0;
            out_pr_reg <= 1'b0;
        end
        else if (cmd.track_fin)
        begin
            if (act_reg)
            begin
                out_exp_reg <= exp_new;
                out_pr_reg <= 1'b1;
                if (pr_sel)
                begin
                    out_peak_reg <= peak_new;
                end
            end
            else
            begin
                in_exp_reg <= exp_new;
                in_pr_reg <= 1'b1;
                if (pr_sel)
                begin
                    in_peak_reg <= peak_new;
                end
            end
        end
    end

    // queue pointers
    logic [AW-1:0] head_reg;
    logic [CW-1:0] count_reg;
    logic [AW-1:0] head_inc, waddr;
    logic [AW:0] wsum;
    logic [TIME_BITS-1:0] rdata;
    logic [CW-1:0] dropped_reg;
    logic delivered_reg, underrun_reg;
    logic [TIME_BITS-1:0] ftime_reg, lat_reg;

    assign head_inc = (head_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign wsum = {1'b0, head_reg} + (AW+1)'(count_reg);
    assign waddr = (wsum >= (AW+1)'(QUEUE_DEPTH)) ? AW'(wsum - (AW+1)'(QUEUE_DEPTH))
                                                   : wsum[AW-1:0];

    jtq_ram #(.WIDTH(TIME_BITS), .DEPTH(QUEUE_DEPTH)) u_ram (
        .clk   (clk),
        .we    (cmd.mem_wr),
        .waddr (waddr),
        .wdata (now_reg),
        .raddr (head_reg),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (cmd.pop || cmd.drop_one)
            begin
                head_reg <= head_inc;
            end
            if (cmd.mem_wr && !cmd.pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if ((cmd.pop || cmd.drop_one) && !cmd.mem_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // result bookkeeping; mem_rd marks the cycle the head entry is valid
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            dropped_reg <= '0;
            delivered_reg <= 1'b0;
            underrun_reg <= 1'b0;
            ftime_reg <= '0;
            lat_reg <= '0;
        end
        else
        begin
            if (cmd.mem_rd)
            begin
                if (count_reg == '0)
                begin
                    underrun_reg <= 1'b1;
                end
                else
                begin
                    delivered_reg <= 1'b1;
                    ftime_reg <= rdata;
                    lat_reg <= now_reg - rdata;
                end
            end
            if (cmd.drop_one || (cmd.pop && !act_reg))
            begin
                dropped_reg <= dropped_reg + 1'b1;
            end
        end
    end

    // division operand: term + margin + out peak, signed 66 bit
    logic [63:0] term, t1;
    logic signed [65:0] total;
    logic [DIV_W-1:0] dividend_reg;
    logic pos_reg;
    logic [TIME_BITS-1:0] ahead, behind;
    assign ahead = in_exp_reg - now_reg;
    assign behind = now_reg - in_exp_reg;

    always_comb
    begin
        term = '0;
        t1 = '0;
        if (in_pr_reg)
        begin
            if (in_exp_reg >= now_reg)
            begin
                t1 = 64'(ahead);
                if (t1 > SAT)
                begin
                    t1 = SAT;
                end
                term = t1 + 64'(in_peak_reg);
                if (term > SAT)
                begin
                    term = SAT;
                end
            end
            else if (64'(in_peak_reg) > 64'(behind))
            begin
                term = 64'(in_peak_reg) - 64'(behind);
            end
        end
        total = $signed({2'b00, term}) + 66'(margin_reg) + $signed(66'(out_peak_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= 1'b0;
        end
        else if (cmd.term)
        begin
            pos_reg <= (total > 0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.term)
        begin
            dividend_reg <= total[DIV_W-1:0];
        end
    end

    logic [DIV_W-1:0] quot;
    logic div_done;
    logic [PERIOD_W-1:0] per;
    assign per = (period_reg == '0) ? PERIOD_W'(1) : period_reg;

    jtq_div #(.N(DIV_W), .D(PERIOD_W)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (dividend_reg),
        .divisor  (per),
        .done     (div_done),
        .quotient (quot)
    );

    logic [CW-1:0] safe_reg;
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            safe_reg <= '0;
        end
        else if (div_done)
        begin
            if (!pos_reg)
            begin
                safe_reg <= '0;
            end
            else if (quot > DIV_W'(QUEUE_DEPTH))
            begin
                safe_reg <= CW'(QUEUE_DEPTH);
            end
            else
            begin
                safe_reg <= quot[CW-1:0];
            end
        end
    end

    assign stat.is_dep = act_reg;
    assign stat.full = (count_reg >= CW'(QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign stat.div_done = div_done;
    assign stat.over_safe = (count_reg > safe_reg);

    logic [OUT_TW+OUT_TW+3*CNT_OUT_W+1:0] res_reg;
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            res_reg <= {CNT_OUT_W'(count_reg), CNT_OUT_W'(safe_reg),
                        CNT_OUT_W'(dropped_reg), OUT_TW'(lat_reg),
                        OUT_TW'(ftime_reg), underrun_reg, delivered_reg};
        end
    end
    assign result = res_reg;
endmodule

>>> rtl/jtq_ctrl.sv
// Controller state machine sequencing one event through the datapath.
// Depends on jtq_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "jitter_tracking_frame_queue_drop_macros.svh"
module jtq_ctrl
    import jtq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_fire,
    output logic      in_rdy,
    input  logic      out_busy,
    input  logic      out_fire,
    output logic      out_set,
    input  jtq_stat_t stat,
    output jtq_cmd_t  cmd
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MUL   = 4'd1;
    localparam logic [3:0] S_TRK   = 4'd2;
    localparam logic [3:0] S_ARR   = 4'd3;
    localparam logic [3:0] S_RD    = 4'd4;
    localparam logic [3:0] S_POP   = 4'd5;
    localparam logic [3:0] S_TERM  = 4'd6;
    localparam logic [3:0] S_DIVS  = 4'd7;
    localparam logic [3:0] S_DIVW  = 4'd8;
    localparam logic [3:0] S_DROP  = 4'd9;
    localparam logic [3:0] S_OUT   = 4'd10;
    localparam logic [3:0] S_RDW   = 4'd11;

    logic [3:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        out_set = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    cmd.load = 1'b1;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.track = 1'b1;
                state_next = S_TRK;
            end
            S_TRK:
            begin
                cmd.track_fin = 1'b1;
                state_next = stat.is_dep ? S_RDW : S_ARR;
            end
            S_ARR:
            begin
                // full queue: drop the oldest while enqueueing
                cmd.mem_wr = 1'b1;
                cmd.pop = stat.full;
                state_next = S_OUT;
            end
            S_RDW:
            begin
                state_next = S_RD;
            end
            S_RD:
            begin
                cmd.mem_rd = 1'b1;
                state_next = stat.empty ? S_TERM : S_POP;
            end
            S_POP:
            begin
                cmd.pop = 1'b1;
                state_next = S_TERM;
            end
            S_TERM:
            begin
                cmd.term = 1'b1;
                state_next = S_DIVS;
            end
            S_DIVS:
            begin
                cmd.div_start = 1'b1;
                state_next = S_DIVW;
            end
            S_DIVW:
            begin
                if (stat.div_done)
                begin
                    state_next = S_DROP;
                end
            end
            S_DROP:
            begin
                if (stat.over_safe)
                begin
                    cmd.drop_one = 1'b1;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                // wait for the output register to free up
                if (!out_busy || out_fire)
                begin
                    cmd.out_load = 1'b1;
                    out_set = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_rdy = (state_reg == S_IDLE);

    `JTQ_ASSERT(a_load_idle, clk, rst_n, cmd.load |-> state_reg == S_IDLE, "load outside idle")
    `JTQ_ASSERT(a_wr_pop_arr, clk, rst_n, (cmd.mem_wr && cmd.pop) |-> stat.full, "pop on write without full")
    `JTQ_ASSERT(a_div_wait, clk, rst_n, cmd.div_start |=> state_reg == S_DIVW, "divider not awaited")
    `JTQ_ASSERT_ALWAYS(a_single_op, clk, !(cmd.drop_one && cmd.mem_wr), "drop during enqueue")
endmodule

>>> rtl/jitter_tracking_frame_queue_drop.sv
// Top level of the jitter tracking frame queue with adaptive dropping.
// Depends on jtq_pkg, jtq_ctrl, jtq_datapath.
//
// channel   | direction | content
// s_axis    | in        | tuser = action, tdata = timestamp_us
// m_axis    | out       | tdata = result fields, tuser = delivered/underrun
// cfg       | in        | register index and write data
//
// One event at a time. A departure runs the 64-step radix-2 divide by the
// frame period, then drops frames while the queue is over the safe length. The result sits in
// an output register while the next event is taken. Reset clears queue and
// trackers and loads the register defaults; the frame store needs no clearing.
`timescale 1ns / 1ps
module jitter_tracking_frame_queue_drop
    import jtq_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int TIME_BITS   = DEF_TIME_BITS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [39:0]           s_axis_tdata,  // timestamp_us
    input  logic                  s_axis_tuser,  // action
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // frame_time_us, latency_us, dropped, safe_length, queue_level, pad
    output logic [103:0]          m_axis_tdata,
    output logic [1:0]            m_axis_tuser,  // delivered, underrun
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);
    jtq_cmd_t  cmd;
    jtq_stat_t stat;
    logic in_fire, out_fire, out_set, vld_reg;
    logic [OUT_TW+OUT_TW+3*CNT_OUT_W+1:0] result;

    assign in_fire = s_axis_tvalid && s_axis_tready;
    assign out_fire = m_axis_tvalid && m_axis_tready;
    assign cfg_ready = 1'b1;

    jtq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .in_rdy   (s_axis_tready),
        .out_busy (vld_reg),
        .out_fire (out_fire),
        .out_set  (out_set),
        .stat     (stat),
        .cmd      (cmd)
    );

    jtq_datapath #(.QUEUE_DEPTH(QUEUE_DEPTH), .TIME_BITS(TIME_BITS)) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid),
        .cfg_idx   (cfg_index),
        .cfg_data  (cfg_data),
        .in_action (s_axis_tuser),
        .in_time   (s_axis_tdata),
        .cmd       (cmd),
        .stat      (stat),
        .result    (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (out_set)
        begin
            vld_reg <= 1'b1;
        end
        else if (out_fire)
        begin
            vld_reg <= 1'b0;
        end
    end

    assign m_axis_tvalid = vld_reg;
    assign m_axis_tuser = result[1:0];
    assign m_axis_tdata = {3'b000, result[OUT_TW+OUT_TW+3*CNT_OUT_W+1:2]};
endmodule
